@@ hw/rtl/iirl_pkg.sv @@
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared types and constants for the indexed insert/remove list.
// ----------------------------------------------------------------------------
`default_nettype none

package iirl_pkg;

  // fixed field widths of the request and result channels
  localparam int POS_W      = 5;
  localparam int XFER_W     = 32;
  localparam int CNT_OUT_W  = 5;

  // defaults for the top-level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // request kinds
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_WRITE  = 2'd3
  } req_type_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             load;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/iirl_if.sv @@
// ----------------------------------------------------------------------------
// iirl_if
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface iirl_req_if
  import iirl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [POS_W-1:0]  position;
  logic [XFER_W-1:0] data_in;

  modport source (output valid, output req_type, output position, output data_in,
                  input ready);
  modport sink   (input valid, input req_type, input position, input data_in,
                  output ready);
endinterface

interface iirl_rsp_if
  import iirl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [XFER_W-1:0]    read_data;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output ok, output read_data, output entry_count,
                  input ready);
  modport sink   (input valid, input ok, input read_data, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/iirl_cell.sv @@
// ----------------------------------------------------------------------------
// iirl_cell
// One list slot: holds a word and takes it from a neighbour on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_cell
  import iirl_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire cell_cmd_t             cmd,
  input  wire logic [DATA_WIDTH-1:0] word,
  input  wire logic [DATA_WIDTH-1:0] lower_data,
  input  wire logic [DATA_WIDTH-1:0] upper_data,
  output logic      [DATA_WIDTH-1:0] data_q,
  output logic      [DATA_WIDTH-1:0] sel_data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  above_pos;
  logic                  at_pos;

  // position compare against this slot
  assign at_pos    = (IDX == int'(cmd.pos));
  assign above_pos = (IDX >  int'(cmd.pos));

  // slot update: shift up from below, load at position, shift down from above
  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up && above_pos) begin
      data_nxt = lower_data;
    end else if (cmd.load && at_pos) begin
      data_nxt = word;
    end else if (cmd.shift_down && (above_pos || at_pos)) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q   = data_r;
  assign sel_data = at_pos ? data_r : '0;

endmodule

`default_nettype wire

@@ hw/rtl/iirl_ctrl.sv @@
// ----------------------------------------------------------------------------
// iirl_ctrl
// Request decode, range check and entry count for the list.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_ctrl
  import iirl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [1:0]       req_type,
  input  wire logic [POS_W-1:0] position,
  output cell_cmd_t             cmd,
  output logic                  ok,
  output logic                  rd_en,
  output logic      [CNT_W-1:0] count_nxt
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  req_type_t        kind;

  assign kind    = req_type_t'(req_type);
  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(DEPTH));

  // range check and cell command
  always_comb begin
    ok             = 1'b0;
    rd_en          = 1'b0;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.load       = 1'b0;
    cmd.pos        = position;
    count_nxt      = count_r;
    case (kind)
      REQ_INSERT: begin
        ok = (pos_ext <= cnt_ext) && !full;
        cmd.shift_up = accept && ok;
        cmd.load     = accept && ok;
        if (ok) count_nxt = count_r + CNT_W'(1);
      end
      REQ_REMOVE: begin
        ok = (pos_ext < cnt_ext);
        cmd.shift_down = accept && ok;
        if (ok) count_nxt = count_r - CNT_W'(1);
      end
      REQ_READ: begin
        ok    = (pos_ext < cnt_ext);
        rd_en = ok;
      end
      REQ_WRITE: begin
        ok       = (pos_ext < cnt_ext);
        cmd.load = accept && ok;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // count stays within the row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // shifts in both directions never together
  a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.shift_up, cmd.shift_down}))
    else $error("shift up and down at once");

  // a successful insert grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_up |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow count");

  // a refused request leaves the count alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ok) |=> (count_r == $past(count_r)))
    else $error("refused request changed count");

endmodule

`default_nettype wire

@@ hw/rtl/indexed_insert_remove_list.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Ordered list of up to DEPTH words with insert, remove, read and write
// at a position, built as a row of shifting slot cells.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  in_req    in   req_type, position, data_in      valid/ready
//  out_rsp   out  ok, read_data, entry_count       valid/ready
//
//  one request per cycle; its result appears in the output register on the
//  next cycle, as all slots shift or load together in the cycle of the request.
//  in_req.ready drops only while a result waits and out_rsp.ready is low.
//  reset clears the entry count and the output valid; slot words are
//  undefined until written and never read before that.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list
  import iirl_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  iirl_req_if.sink    in_req,
  iirl_rsp_if.source  out_rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_cmd_t             cmd;
  logic                  accept;
  logic                  ok;
  logic                  rd_en;
  logic [CNT_W-1:0]      count_nxt;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
  logic [DATA_WIDTH-1:0] sel_q    [DEPTH];
  logic [DATA_WIDTH-1:0] rd_word;

  logic                  out_valid_r;
  logic                  ok_r;
  logic [XFER_W-1:0]     rdata_r;
  logic [CNT_OUT_W-1:0]  cnt_r;

  // handshake: take a request unless a result is stuck
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign word         = DATA_WIDTH'(in_req.data_in);

  // decode and count
  iirl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req.req_type),
    .position  (in_req.position),
    .cmd       (cmd),
    .ok        (ok),
    .rd_en     (rd_en),
    .count_nxt (count_nxt)
  );

  // row of slot cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_d;
    logic [DATA_WIDTH-1:0] upper_d;
    if (g == 0) begin : g_lo_end
      assign lower_d = '0;
    end else begin : g_lo
      assign lower_d = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi_end
      assign upper_d = '0;
    end else begin : g_hi
      assign upper_d = cell_q[g+1];
    end
    iirl_cell #(.DATA_WIDTH(DATA_WIDTH), .IDX(g)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .word       (word),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .data_q     (cell_q[g]),
      .sel_data   (sel_q[g])
    );
  end

  // read select: only the addressed slot drives a word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | sel_q[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r    <= ok;
      rdata_r <= rd_en ? XFER_W'(rd_word) : '0;
      cnt_r   <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = ok_r;
  assign out_rsp.read_data   = rdata_r;
  assign out_rsp.entry_count = cnt_r;

endmodule

`default_nettype wire

@@ test/indexed_insert_remove_list_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_tb
// Self-checking bench for the indexed insert/remove list. Requests are driven
// on the valid/ready input channel and each one is run through a local list
// model at acceptance. Every result taken from the output channel is compared
// field by field with the oldest predicted one. Directed cases cover the
// empty and full list and refused positions. Random phases follow, with
// sender gaps and receiver stalls, and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list_tb;
  import iirl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int STORED_W    = (DATA_WIDTH_DEF < XFER_W) ? DATA_WIDTH_DEF : XFER_W;
  localparam logic [XFER_W-1:0] WORD_MASK = {XFER_W{1'b1}} >> (XFER_W - STORED_W);
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 310;

  typedef struct packed {
    logic                 ok;
    logic [XFER_W-1:0]    read_data;
    logic [CNT_OUT_W-1:0] entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  iirl_req_if req_bus ();
  iirl_rsp_if rsp_bus ();

  indexed_insert_remove_list u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  // local copy of the list contents
  logic [XFER_W-1:0] list_words [LIST_DEPTH];
  int                list_len;

  list_result_t pending_results [$];
  list_result_t oldest_result;
  int           error_count;
  int           cycle_count = 0;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_off_cycles;
  int           fill_target;

  // clock
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // list update and result for one accepted request
  function automatic list_result_t apply_request(req_type_t kind, logic [POS_W-1:0] pos,
                                                 logic [XFER_W-1:0] word);
    list_result_t res;
    int           i;
    res = '0;
    case (kind)
      REQ_INSERT: begin
        if (pos <= list_len && list_len < LIST_DEPTH) begin
          for (i = list_len; i > pos; i--) list_words[IDX_W'(i)] = list_words[IDX_W'(i-1)];
          list_words[IDX_W'(pos)] = word & WORD_MASK;
          list_len++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos < list_len) begin
          for (i = pos; i + 1 < list_len; i++) list_words[IDX_W'(i)] = list_words[IDX_W'(i+1)];
          list_len--;
          res.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos < list_len) begin
          res.read_data = list_words[IDX_W'(pos)];
          res.ok        = 1'b1;
        end
      end
      default: begin
        if (pos < list_len) begin
          list_words[IDX_W'(pos)] = word & WORD_MASK;
          res.ok                  = 1'b1;
        end
      end
    endcase
    res.entry_count = list_len[CNT_OUT_W-1:0];
    return res;
  endfunction

  // offer one request, wait for the handshake, then predict its result
  task automatic send_request(req_type_t kind, logic [POS_W-1:0] pos,
                              logic [XFER_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.position <= pos;
    req_bus.data_in  <= word;
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(apply_request(kind, pos, word));
  endtask

  // receiver: long hold-off when asked, otherwise random stalls
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: ok=%0b read_data=%h entry_count=%0d",
               rsp_bus.ok, rsp_bus.read_data, rsp_bus.entry_count);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_bus.ok !== oldest_result.ok) begin
          $error("ok: expected %0b, got %0b", oldest_result.ok, rsp_bus.ok);
          error_count++;
        end
        if (rsp_bus.read_data !== oldest_result.read_data) begin
          $error("read_data: expected %h, got %h", oldest_result.read_data,
                 rsp_bus.read_data);
          error_count++;
        end
        if (rsp_bus.entry_count !== oldest_result.entry_count) begin
          $error("entry_count: expected %0d, got %0d", oldest_result.entry_count,
                 rsp_bus.entry_count);
          error_count++;
        end
      end
    end
  end

  // refused requests on an empty list, edge positions and data extremes
  task automatic test_directed();
    int i;
    send_request(REQ_REMOVE, 0, '0);
    send_request(REQ_READ, 0, '0);
    send_request(REQ_WRITE, 0, '1);
    send_request(REQ_INSERT, 1, 32'h0bad_cafe);
    send_request(REQ_INSERT, 0, '1);
    send_request(REQ_INSERT, 0, '0);
    send_request(REQ_INSERT, 2, 32'ha5a5_a5a5);
    send_request(REQ_INSERT, 1, 32'h5a5a_5a5a);
    for (i = 0; i < 4; i++) send_request(REQ_READ, POS_W'(i), '0);
    send_request(REQ_WRITE, 1, 32'h1234_5678);
    send_request(REQ_READ, 1, '0);
    send_request(REQ_READ, 31, '0);
    send_request(REQ_WRITE, 31, '1);
    send_request(REQ_INSERT, 31, '1);
    send_request(REQ_REMOVE, 31, '0);
    send_request(REQ_REMOVE, 1, '0);
    send_request(REQ_REMOVE, 2, '0);
    send_request(REQ_REMOVE, 2, '0);
    send_request(REQ_READ, 1, '0);
  endtask

  // grow to full, hit the full-list refusal, then drain to empty
  task automatic test_fill_and_drain();
    while (list_len < LIST_DEPTH)
      send_request(REQ_INSERT, POS_W'($urandom_range(list_len, 0)), $urandom);
    send_request(REQ_INSERT, POS_W'(LIST_DEPTH), $urandom);
    send_request(REQ_INSERT, 0, $urandom);
    send_request(REQ_READ, POS_W'(LIST_DEPTH - 1), '0);
    send_request(REQ_WRITE, POS_W'(LIST_DEPTH - 1), '1);
    send_request(REQ_READ, POS_W'(LIST_DEPTH - 1), '0);
    send_request(REQ_REMOVE, POS_W'(LIST_DEPTH - 1), '0);
    send_request(REQ_INSERT, POS_W'(LIST_DEPTH - 1), '0);
    while (list_len > 0)
      send_request(REQ_REMOVE, POS_W'($urandom_range(list_len - 1, 0)), '0);
    send_request(REQ_READ, 0, '0);
  endtask

  // random traffic steered towards a moving fill level, with some noise
  task automatic test_random_traffic(int n_items);
    int                k;
    int                sel;
    req_type_t         kind;
    logic [POS_W-1:0]  pos;
    logic [XFER_W-1:0] word;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) fill_target = $urandom_range(LIST_DEPTH, 0);
      sel = $urandom_range(99);
      if (sel < 40)
        kind = (list_len < fill_target) ? REQ_INSERT : REQ_REMOVE;
      else
        kind = req_type_t'($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 8)
        pos = POS_W'($urandom_range(31, 0));
      else if (sel < 14)
        pos = POS_W'((kind == REQ_INSERT) ? list_len + 1 : list_len);
      else if (kind == REQ_INSERT)
        pos = POS_W'($urandom_range(list_len, 0));
      else
        pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1, 0)) : '0;
      sel = $urandom_range(9);
      word = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom;
      send_request(kind, pos, word);
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    fill_target     = LIST_DEPTH;
    hold_off_cycles = 300;
    test_random_traffic(60);
  endtask

  initial begin
    error_count     = 0;
    list_len        = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    fill_target     = 0;
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_INSERT;
    req_bus.position <= '0;
    req_bus.data_in  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random_traffic(PHASE_ITEMS);
    send_idle_pct  = 63;
    test_random_traffic(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    test_random_traffic(PHASE_ITEMS);
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    test_random_traffic(PHASE_ITEMS);
    test_back_pressure();
    req_bus.valid <= 1'b0;

    // drain outstanding results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
